// ===== sv/dgde_pkg.sv =====
`default_nettype none

package dgde_pkg;

  localparam int Q30_W        = 31;
  localparam int EXP_LIMIT    = 18;
  localparam int SERIES_TERMS = 25;
  localparam int EXP_STAGES   = 7;

  localparam logic [63:0] Q30_ONE   = 64'd1 << 30;
  localparam logic [63:0] Q30_HALF  = 64'd1 << 29;
  localparam logic [20:0] ARG_LIMIT = 21'(EXP_LIMIT << 16);

  typedef enum logic [1:0] {
    SEL_TOTAL     = 2'd0,
    SEL_FIRST     = 2'd1,
    SEL_SECOND    = 2'd2,
    SEL_TOTAL_ALT = 2'd3
  } comp_sel_t;

  typedef enum logic [2:0] {
    REG_CENTER     = 3'd0,
    REG_INV_FIRST  = 3'd1,
    REG_INV_SECOND = 3'd2,
    REG_FRACTION   = 3'd3,
    REG_SELECT     = 3'd4
  } cfg_reg_t;

  function automatic logic [63:0] div_by_term(input logic [63:0] x, input logic [4:0] k);
    case (k)
      5'd1:    div_by_term = x / 1;
      5'd2:    div_by_term = x / 2;
      5'd3:    div_by_term = x / 3;
      5'd4:    div_by_term = x / 4;
      5'd5:    div_by_term = x / 5;
      5'd6:    div_by_term = x / 6;
      5'd7:    div_by_term = x / 7;
      5'd8:    div_by_term = x / 8;
      5'd9:    div_by_term = x / 9;
      5'd10:   div_by_term = x / 10;
      5'd11:   div_by_term = x / 11;
      5'd12:   div_by_term = x / 12;
      5'd13:   div_by_term = x / 13;
      5'd14:   div_by_term = x / 14;
      5'd15:   div_by_term = x / 15;
      5'd16:   div_by_term = x / 16;
      5'd17:   div_by_term = x / 17;
      5'd18:   div_by_term = x / 18;
      5'd19:   div_by_term = x / 19;
      5'd20:   div_by_term = x / 20;
      5'd21:   div_by_term = x / 21;
      5'd22:   div_by_term = x / 22;
      5'd23:   div_by_term = x / 23;
      5'd24:   div_by_term = x / 24;
      default: div_by_term = x;
    endcase
  endfunction

  // exp(-t) in q30, alternating series with truncated terms
  function automatic logic [63:0] exp_neg_series(input logic [63:0] t);
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] term;
    pos  = Q30_ONE;
    neg  = '0;
    term = Q30_ONE;
    for (int k = 1; k < SERIES_TERMS; k++) begin
      term = div_by_term((term * t) >> 30, 5'(k));
      if ((k & 1) != 0) begin
        neg = neg + term;
      end else begin
        pos = pos + term;
      end
    end
    return (pos > neg) ? (pos - neg) : 64'd0;
  endfunction

endpackage

`default_nettype wire

// ===== sv/dgde_exp.sv =====
`default_nettype none

module dgde_exp
  import dgde_pkg::*;
#(
  parameter int EXP_TABLE_DEPTH = 256
) (
  input  logic                  clk,
  input  logic [EXP_STAGES-1:0] stage_en,
  input  logic [63:0]           sq,
  input  logic [31:0]           inv,
  output logic [Q30_W-1:0]      g
);

  localparam int IDX_W = $clog2(EXP_TABLE_DEPTH + 1);
  localparam int P_W   = IDX_W + 16;

  typedef logic [Q30_W-1:0] frac_rom_t [EXP_TABLE_DEPTH+1];
  typedef logic [Q30_W-1:0] int_rom_t [EXP_LIMIT];

  function automatic frac_rom_t build_frac_rom();
    frac_rom_t rom;
    for (int i = 0; i <= EXP_TABLE_DEPTH; i++) begin
      rom[i] = Q30_W'(exp_neg_series((64'(i) << 30) / EXP_TABLE_DEPTH));
    end
    return rom;
  endfunction

  function automatic int_rom_t build_int_rom(input logic [Q30_W-1:0] step);
    int_rom_t rom;
    rom[0] = Q30_W'(Q30_ONE);
    for (int i = 1; i < EXP_LIMIT; i++) begin
      rom[i] = Q30_W'((64'(rom[i-1]) * 64'(step) + Q30_HALF) >> 30);
    end
    return rom;
  endfunction

  localparam frac_rom_t FRAC_ROM = build_frac_rom();
  localparam int_rom_t  INT_ROM  = build_int_rom(FRAC_ROM[EXP_TABLE_DEPTH]);

  // argument products
  logic [63:0] hi_prod;
  logic [63:0] lo_prod;
  logic [63:0] m_r;
  logic [31:0] lo_r;

  assign hi_prod = 64'(sq[63:32]) * 64'(inv);
  assign lo_prod = 64'(sq[31:0]) * 64'(inv);

  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      m_r  <= hi_prod;
      lo_r <= lo_prod[63:32];
    end
  end

  // argument sum and saturation
  logic [32:0] a_sum;
  logic        zero_a;
  logic        zero2_r;
  logic [4:0]  n2_r;
  logic [15:0] r2_r;

  assign a_sum  = 33'(m_r[20:0]) + 33'(lo_r);
  assign zero_a = (m_r >= 64'(ARG_LIMIT)) || (a_sum >= 33'(ARG_LIMIT));

  always_ff @(posedge clk) begin
    if (stage_en[1]) begin
      zero2_r <= zero_a;
      n2_r    <= zero_a ? 5'd0 : a_sum[20:16];
      r2_r    <= a_sum[15:0];
    end
  end

  // table lookup
  logic [P_W-1:0]   p;
  logic [IDX_W-1:0] idx;
  logic [15:0]      w3_r;
  logic [Q30_W-1:0] lo3_r;
  logic [Q30_W-1:0] hi3_r;
  logic [4:0]       n3_r;
  logic             zero3_r;

  assign p   = P_W'(r2_r) * P_W'(EXP_TABLE_DEPTH);
  assign idx = p[P_W-1:16];

  always_ff @(posedge clk) begin
    if (stage_en[2]) begin
      w3_r    <= p[15:0];
      lo3_r   <= FRAC_ROM[idx];
      hi3_r   <= FRAC_ROM[idx + IDX_W'(1)];
      n3_r    <= n2_r;
      zero3_r <= zero2_r;
    end
  end

  // interpolation product
  logic             desc;
  logic [Q30_W-1:0] span;
  logic [46:0]      prod4_r;
  logic [Q30_W-1:0] lo4_r;
  logic             desc4_r;
  logic [4:0]       n4_r;
  logic             zero4_r;

  assign desc = lo3_r >= hi3_r;
  assign span = desc ? (lo3_r - hi3_r) : (hi3_r - lo3_r);

  always_ff @(posedge clk) begin
    if (stage_en[3]) begin
      prod4_r <= 47'(span) * 47'(w3_r);
      lo4_r   <= lo3_r;
      desc4_r <= desc;
      n4_r    <= n3_r;
      zero4_r <= zero3_r;
    end
  end

  // interpolated fraction and integer factor
  logic [Q30_W-1:0] f_val;
  logic [Q30_W-1:0] f5_r;
  logic [Q30_W-1:0] e5_r;
  logic             zero5_r;

  assign f_val = desc4_r ? (lo4_r - prod4_r[46:16]) : (lo4_r + prod4_r[46:16]);

  always_ff @(posedge clk) begin
    if (stage_en[4]) begin
      f5_r    <= f_val;
      e5_r    <= INT_ROM[n4_r];
      zero5_r <= zero4_r;
    end
  end

  logic [61:0] prod6_r;
  logic        zero6_r;

  always_ff @(posedge clk) begin
    if (stage_en[5]) begin
      prod6_r <= 62'(e5_r) * 62'(f5_r);
      zero6_r <= zero5_r;
    end
  end

  logic [61:0]      rnd;
  logic [Q30_W-1:0] g_r;

  assign rnd = prod6_r + 62'(Q30_HALF);

  always_ff @(posedge clk) begin
    if (stage_en[6]) begin
      g_r <= zero6_r ? '0 : rnd[60:30];
    end
  end

  assign g = g_r;

endmodule

`default_nettype wire

// ===== sv/double_gaussian_density_eval_unit.sv =====
// throughput: one beat per cycle while out_ready is high, set by the fully
// pipelined datapath (distance, square, exponent argument, table
// interpolation, weighting and output rounding stages)
// reset (rst_n low, synchronous): all pipeline valid bits clear and the
// configuration registers return to their defaults; exp tables are constants
`default_nettype none

module double_gaussian_density_eval_unit
  import dgde_pkg::*;
#(
  parameter int EXP_TABLE_DEPTH = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_x_sample,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [24:0]        out_density,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_wdata
);

  localparam int NUM_STAGES = EXP_STAGES + 4;
  localparam int ST_DIFF    = 0;
  localparam int ST_SQ      = 1;
  localparam int ST_EXP     = 2;
  localparam int ST_WEIGHT  = ST_EXP + EXP_STAGES;
  localparam int ST_OUT     = ST_WEIGHT + 1;

  // configuration registers
  logic signed [31:0] center_offset_r;
  logic [31:0]        inv_first_r;
  logic [31:0]        inv_second_r;
  logic [16:0]        fraction_r;
  comp_sel_t          select_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_offset_r <= '0;
      inv_first_r     <= 32'd32768;
      inv_second_r    <= 32'd32768;
      fraction_r      <= 17'd32768;
      select_r        <= SEL_TOTAL;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_CENTER:     center_offset_r <= cfg_wdata;
        REG_INV_FIRST:  inv_first_r     <= cfg_wdata;
        REG_INV_SECOND: inv_second_r    <= cfg_wdata;
        REG_FRACTION:   fraction_r      <= cfg_wdata[16:0];
        REG_SELECT:     select_r        <= comp_sel_t'(cfg_wdata[1:0]);
        default: ;
      endcase
    end
  end

  // pipeline control
  logic [NUM_STAGES-1:0] valid_r;
  logic [NUM_STAGES-1:0] valid_nxt;
  logic [NUM_STAGES-1:0] adv;

  always_comb begin
    adv[NUM_STAGES-1] = !valid_r[NUM_STAGES-1] || out_ready;
    for (int i = NUM_STAGES - 2; i >= 0; i--) begin
      adv[i] = !valid_r[i] || adv[i+1];
    end
  end

  always_comb begin
    valid_nxt[0] = adv[0] ? in_valid : valid_r[0];
    for (int i = 1; i < NUM_STAGES; i++) begin
      valid_nxt[i] = adv[i] ? valid_r[i-1] : valid_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign in_ready = adv[0];

  // distance from center
  logic [32:0] diff;
  logic [31:0] mag;
  logic [31:0] mag_r;

  assign diff = {in_x_sample[31], in_x_sample} - {center_offset_r[31], center_offset_r};
  assign mag  = diff[32] ? 32'(~diff + 33'd1) : diff[31:0];

  always_ff @(posedge clk) begin
    if (adv[ST_DIFF]) begin
      mag_r <= mag;
    end
  end

  logic [63:0] sq_r;

  always_ff @(posedge clk) begin
    if (adv[ST_SQ]) begin
      sq_r <= 64'(mag_r) * 64'(mag_r);
    end
  end

  // one exp unit per gaussian
  logic [Q30_W-1:0] g_first;
  logic [Q30_W-1:0] g_second;

  dgde_exp #(
    .EXP_TABLE_DEPTH(EXP_TABLE_DEPTH)
  ) u_exp_first (
    .clk      (clk),
    .stage_en (adv[ST_EXP +: EXP_STAGES]),
    .sq       (sq_r),
    .inv      (inv_first_r),
    .g        (g_first)
  );

  dgde_exp #(
    .EXP_TABLE_DEPTH(EXP_TABLE_DEPTH)
  ) u_exp_second (
    .clk      (clk),
    .stage_en (adv[ST_EXP +: EXP_STAGES]),
    .sq       (sq_r),
    .inv      (inv_second_r),
    .g        (g_second)
  );

  // weighting
  logic [16:0] wf;
  logic [16:0] wf2;
  logic [47:0] term_first_r;
  logic [47:0] term_second_r;

  assign wf  = (fraction_r > 17'd65536) ? 17'd65536 : fraction_r;
  assign wf2 = 17'd65536 - wf;

  always_ff @(posedge clk) begin
    if (adv[ST_WEIGHT]) begin
      term_first_r  <= 48'(g_first) * 48'(wf);
      term_second_r <= 48'(g_second) * 48'(wf2);
    end
  end

  // select and round to q1.24
  logic [48:0] sum_sel;
  logic [48:0] sum_rnd;
  logic [24:0] density_r;

  always_comb begin
    case (select_r)
      SEL_FIRST:  sum_sel = 49'(term_first_r);
      SEL_SECOND: sum_sel = 49'(term_second_r);
      default:    sum_sel = 49'(term_first_r) + 49'(term_second_r);
    endcase
  end

  assign sum_rnd = sum_sel + (49'd1 << 21);

  always_ff @(posedge clk) begin
    if (adv[ST_OUT]) begin
      density_r <= sum_rnd[46:22];
    end
  end

  assign out_valid   = valid_r[ST_OUT];
  assign out_density = density_r;

`ifndef ASSERT_OFF
  a_density_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_density <= 25'h1000000))
    else $error("density above one");

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> valid_r[ST_DIFF])
    else $error("accepted beat missing from first stage");

  a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ready && out_valid && !out_ready) |-> !(&valid_r))
    else $error("input taken while pipeline full and stalled");
`endif

endmodule

`default_nettype wire
